/* rtl/core/bpa_pkg.sv */
// bpa_pkg: shared types, constants and helper functions of the bitmap page allocator.
// Depends on nothing; every module of the allocator imports it.
`timescale 1ns / 1ps

package bpa_pkg;

  // Field widths fixed by the request and response words
  localparam int unsigned SlotW    = 4;
  localparam int unsigned HolderW  = 2;
  localparam int unsigned PageW    = 4;
  localparam int unsigned SegW     = 4;
  localparam int unsigned ValW     = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned ScanW    = 16;

  // Default geometry
  localparam int unsigned DefMaxSegments    = 16;
  localparam int unsigned DefHolders        = 4;
  localparam int unsigned DefPagesPerHolder = 16;

  // Register indexes and reset values
  localparam logic [CfgIdxW-1:0] CfgFirstSeg = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgLastSeg  = CfgIdxW'(1);
  localparam logic [SegW-1:0]    FirstSegRst = SegW'(0);
  localparam logic [SegW-1:0]    LastSegRst  = SegW'(15);

  // Operation codes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef struct packed {
    logic               op;
    logic [SlotW-1:0]   slot_index;
    logic [HolderW-1:0] holder_index;
    logic [PageW-1:0]   page_index;
  } bpa_req_t;

  typedef struct packed {
    logic               granted;
    logic [SlotW-1:0]   out_slot;
    logic [HolderW-1:0] out_holder;
    logic [PageW-1:0]   out_page;
    logic [ValW-1:0]    segment_value;
    logic [ValW-1:0]    page_offset;
  } bpa_rsp_t;

  // Range settings handed from the register block to the sequencer
  typedef struct packed {
    logic [SegW-1:0]   first_segment;
    logic [CountW-1:0] slot_count;
  } bpa_cfg_t;

  // Segment register value: segment number in the top nibble
  function automatic logic [ValW-1:0] seg_value(logic [SegW-1:0] first,
                                                logic [SlotW-1:0] slot);
    logic [SegW-1:0] seg;
    seg = SegW'(first + slot);
    return {seg, 12'b0};
  endfunction

  // Offset within segment: holder in bits 15:14, page in bits 13:10
  function automatic logic [ValW-1:0] page_off(logic [HolderW-1:0] holder,
                                               logic [PageW-1:0] page);
    return {holder, page, 10'b0};
  endfunction

  // Lowest clear bit of a used word; found is low when every bit is set
  function automatic logic [PageW:0] first_zero(logic [ScanW-1:0] bits);
    logic [PageW:0] res;
    res = '0;
    for (int i = ScanW - 1; i >= 0; i--) begin
      if (!bits[i]) begin
        res = {1'b1, PageW'(i)};
      end
    end
    return res;
  endfunction

endpackage

/* rtl/core/bpa_bitmap_ram.sv */
// bpa_bitmap_ram: single-port-read, single-port-write used bitmap with registered read data.
// Per-word valid flags make unwritten words read as all free after reset. Uses bpa_pkg.
`timescale 1ns / 1ps

module bpa_bitmap_ram
  import bpa_pkg::*;
#(
  parameter int unsigned Depth = DefMaxSegments * DefHolders,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = DefPagesPerHolder
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [DataW-1:0] rdata_q;
  logic             rvalid_q;

  // Storage array and registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem_q[rd_addr_i];
  end

  // Written flags, cleared at once by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_addr_i];
    end
  end

  // A never-written word reads as all pages free
  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/core/bpa_scan_ctrl.sv */
// bpa_scan_ctrl: request sequencer, first-fit scan over the bitmap memory and result register.
// Drives the read and write ports of bpa_bitmap_ram. Uses bpa_pkg.
`timescale 1ns / 1ps

module bpa_scan_ctrl
  import bpa_pkg::*;
#(
  parameter int unsigned HOLDERS          = DefHolders,
  parameter int unsigned PAGES_PER_HOLDER = DefPagesPerHolder,
  parameter int unsigned AddrW            = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpa_cfg_t                    cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bpa_req_t                    in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bpa_rsp_t                    out_rsp_o,
  output logic [AddrW-1:0]            mem_rd_addr_o,
  input  logic [PAGES_PER_HOLDER-1:0] mem_rd_data_i,
  output logic                        mem_wr_en_o,
  output logic [AddrW-1:0]            mem_wr_addr_o,
  output logic [PAGES_PER_HOLDER-1:0] mem_wr_data_o
);

  localparam int unsigned DataW = PAGES_PER_HOLDER;

  typedef enum logic [1:0] {
    StIdle,
    StFree,
    StScan,
    StDone
  } state_e;

  state_e             state_q, state_d;
  logic [SlotW-1:0]   rd_slot_q, rd_slot_d;
  logic [HolderW-1:0] rd_holder_q, rd_holder_d;
  logic [SlotW-1:0]   chk_slot_q, chk_slot_d;
  logic [HolderW-1:0] chk_holder_q, chk_holder_d;
  logic [PageW-1:0]   page_q, page_d;
  logic               wr_en_q, wr_en_d;
  logic [AddrW-1:0]   wr_addr_q, wr_addr_d;
  logic [DataW-1:0]   wr_data_q, wr_data_d;
  bpa_rsp_t           res_q, res_d;
  logic               out_valid_q, out_valid_d;
  bpa_rsp_t           out_q, out_d;

  logic [ScanW-1:0]   word_ext;
  logic [PageW:0]     zero_hit;
  logic               last_word;
  logic               free_ok;

  // Word address of a (slot, holder) pair
  function automatic logic [AddrW-1:0] word_addr(logic [SlotW-1:0] slot,
                                                 logic [HolderW-1:0] holder);
    return AddrW'(32'(slot) * HOLDERS + 32'(holder));
  endfunction

  // Scan order successor: holders inside a slot, then the next slot
  function automatic logic [SlotW+HolderW-1:0] next_pos(logic [SlotW-1:0] slot,
                                                        logic [HolderW-1:0] holder);
    logic [SlotW+HolderW-1:0] res;
    if (32'(holder) == HOLDERS - 1) begin
      res = {SlotW'(slot + SlotW'(1)), HolderW'(0)};
    end else begin
      res = {slot, HolderW'(holder + HolderW'(1))};
    end
    return res;
  endfunction

  // Pages beyond the holder size count as used
  always_comb begin
    word_ext = '1;
    word_ext[DataW-1:0] = mem_rd_data_i;
  end

  assign zero_hit  = first_zero(word_ext);
  assign last_word = (CountW'(chk_slot_q) == CountW'(cfg_i.slot_count - CountW'(1))) &&
                     (32'(chk_holder_q) == HOLDERS - 1);
  assign free_ok   = (CountW'(in_req_i.slot_index) < cfg_i.slot_count) &&
                     (32'(in_req_i.holder_index) < HOLDERS) &&
                     (32'(in_req_i.page_index) < PAGES_PER_HOLDER);

  assign in_ready_o = (state_q == StIdle);

  // Next state, memory port and result logic
  always_comb begin
    state_d       = state_q;
    rd_slot_d     = rd_slot_q;
    rd_holder_d   = rd_holder_q;
    chk_slot_d    = chk_slot_q;
    chk_holder_d  = chk_holder_q;
    page_d        = page_q;
    wr_en_d       = wr_en_q;
    wr_addr_d     = wr_addr_q;
    wr_data_d     = wr_data_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    mem_rd_addr_o = word_addr(rd_slot_q, rd_holder_q);
    mem_wr_en_o   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          res_d   = '0;
          wr_en_d = 1'b0;
          if (in_req_i.op == OpFree) begin
            page_d        = in_req_i.page_index;
            wr_addr_d     = word_addr(in_req_i.slot_index, in_req_i.holder_index);
            mem_rd_addr_o = wr_addr_d;
            state_d       = free_ok ? StFree : StDone;
          end else if (cfg_i.slot_count == '0) begin
            state_d = StDone;
          end else begin
            // Start the scan at the first word; its data lands next cycle
            mem_rd_addr_o              = word_addr(SlotW'(0), HolderW'(0));
            chk_slot_d                 = '0;
            chk_holder_d               = '0;
            {rd_slot_d, rd_holder_d}   = next_pos(SlotW'(0), HolderW'(0));
            state_d                    = StScan;
          end
        end
      end

      StFree: begin
        wr_en_d       = 1'b1;
        wr_data_d     = mem_rd_data_i & ~(DataW'(1) << page_q);
        res_d         = '0;
        res_d.granted = 1'b1;
        state_d       = StDone;
      end

      StScan: begin
        wr_addr_d = word_addr(chk_slot_q, chk_holder_q);
        if (zero_hit[PageW]) begin
          wr_en_d             = 1'b1;
          wr_data_d           = mem_rd_data_i | (DataW'(1) << zero_hit[PageW-1:0]);
          res_d.granted       = 1'b1;
          res_d.out_slot      = chk_slot_q;
          res_d.out_holder    = chk_holder_q;
          res_d.out_page      = zero_hit[PageW-1:0];
          res_d.segment_value = seg_value(cfg_i.first_segment, chk_slot_q);
          res_d.page_offset   = page_off(chk_holder_q, zero_hit[PageW-1:0]);
          state_d             = StDone;
        end else if (last_word) begin
          wr_en_d = 1'b0;
          res_d   = '0;
          state_d = StDone;
        end else begin
          // Read of rd position is in flight; it is checked next cycle
          chk_slot_d               = rd_slot_q;
          chk_holder_d             = rd_holder_q;
          {rd_slot_d, rd_holder_d} = next_pos(rd_slot_q, rd_holder_q);
        end
      end

      StDone: begin
        // Write back and hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          mem_wr_en_o = wr_en_q;
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign mem_wr_addr_o = wr_addr_q;
  assign mem_wr_data_o = wr_data_q;
  assign out_valid_o   = out_valid_q;
  assign out_rsp_o     = out_q;

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      rd_slot_q    <= '0;
      rd_holder_q  <= '0;
      chk_slot_q   <= '0;
      chk_holder_q <= '0;
      page_q       <= '0;
      wr_en_q      <= 1'b0;
      wr_addr_q    <= '0;
      wr_data_q    <= '0;
      res_q        <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      rd_slot_q    <= rd_slot_d;
      rd_holder_q  <= rd_holder_d;
      chk_slot_q   <= chk_slot_d;
      chk_holder_q <= chk_holder_d;
      page_q       <= page_d;
      wr_en_q      <= wr_en_d;
      wr_addr_q    <= wr_addr_d;
      wr_data_q    <= wr_data_d;
      res_q        <= res_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

endmodule

/* rtl/core/bitmap_page_allocator_core.sv */
// bitmap_page_allocator_core: top level, range registers, slot count, sequencer and bitmap.
// Instantiates bpa_scan_ctrl and bpa_bitmap_ram. Uses bpa_pkg.
//
//   channel   signals                               direction  moves
//   ------------------------------------------------------------------------------
//   in        in_valid_i / in_ready_o / in_req_i    in         request word
//   out       out_valid_o / out_ready_i / out_rsp_o out        response word
//   cfg       cfg_valid_i / cfg_ready_o / cfg_*_i   in         register word
//
// A free request passes through StFree (skipped for an out-of-range index) and then
// StDone; an allocate request checks W bitmap words in StScan, W at most
// slot count * HOLDERS, then enters StDone. The single memory read port
// scans one word per cycle.
// Reset clears every used bit at once through per-word written flags; no sweep.
// A new request is accepted while a response waits; a finished request holds its
// write-back until the output register is free.
`timescale 1ns / 1ps

module bitmap_page_allocator_core
  import bpa_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS     = DefMaxSegments,
  parameter int unsigned HOLDERS          = DefHolders,
  parameter int unsigned PAGES_PER_HOLDER = DefPagesPerHolder
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bpa_req_t            in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bpa_rsp_t            out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_SEGMENTS * HOLDERS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [SegW-1:0]             seg_lo_q;
  logic [SegW-1:0]             seg_hi_q;
  logic [CountW-1:0]           span;
  bpa_cfg_t                    cfg;
  logic [AddrW-1:0]            mem_rd_addr;
  logic [PAGES_PER_HOLDER-1:0] mem_rd_data;
  logic                        mem_wr_en;
  logic [AddrW-1:0]            mem_wr_addr;
  logic [PAGES_PER_HOLDER-1:0] mem_wr_data;

  // Range registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_lo_q <= FirstSegRst;
      seg_hi_q <= LastSegRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFirstSeg: seg_lo_q <= cfg_data_i;
        CfgLastSeg:  seg_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Managed slot count, zero for an inverted range, capped at MAX_SEGMENTS
  assign span = CountW'(seg_hi_q) - CountW'(seg_lo_q) + CountW'(1);

  always_comb begin
    cfg.first_segment = seg_lo_q;
    if (seg_hi_q < seg_lo_q) begin
      cfg.slot_count = '0;
    end else if (32'(span) > MAX_SEGMENTS) begin
      cfg.slot_count = CountW'(MAX_SEGMENTS);
    end else begin
      cfg.slot_count = span;
    end
  end

  bpa_scan_ctrl #(
    .HOLDERS         (HOLDERS),
    .PAGES_PER_HOLDER(PAGES_PER_HOLDER),
    .AddrW           (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_o    (out_rsp_o),
    .mem_rd_addr_o(mem_rd_addr),
    .mem_rd_data_i(mem_rd_data),
    .mem_wr_en_o  (mem_wr_en),
    .mem_wr_addr_o(mem_wr_addr),
    .mem_wr_data_o(mem_wr_data)
  );

  bpa_bitmap_ram #(
    .Depth(Depth),
    .AddrW(AddrW),
    .DataW(PAGES_PER_HOLDER)
  ) u_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(mem_rd_addr),
    .rd_data_o(mem_rd_data),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(mem_wr_addr),
    .wr_data_i(mem_wr_data)
  );

endmodule
